// ===== rtl/m4mul_pkg.sv =====
// Package for the 4x4 matrix product core: beat structs, matrix type, constants.
// Used by every module under rtl/. No dependencies.
package m4mul_pkg;

	localparam int MAT_DIM       = 4;
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int FRAC_BITS_DEF = 16;

	// Item opcodes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MUL  = 1'b1
	} op_t;

	typedef logic signed [DATA_W-1:0] elem_t;

	// Right-hand matrix, indexed [row][col]
	typedef elem_t [MAT_DIM-1:0][MAT_DIM-1:0] mat_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] row_index;
		elem_t      value0;
		elem_t      value1;
		elem_t      value2;
		elem_t      value3;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] result_row;
		elem_t      product0;
		elem_t      product1;
		elem_t      product2;
		elem_t      product3;
		logic       overflow;
	} out_beat_t;

endpackage

// ===== rtl/m4mul_store.sv =====
// Right-hand matrix store: 16 elements in flops, written one row per load beat.
// Depends on m4mul_pkg.
module m4mul_store import m4mul_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_row,
	input  elem_t      wr_val0,
	input  elem_t      wr_val1,
	input  elem_t      wr_val2,
	input  elem_t      wr_val3,
	output mat_t       mat
);

	mat_t mat_q;

	// Row write; reset clears the whole matrix to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (wr_en) begin
			mat_q[wr_row][0] <= wr_val0;
			mat_q[wr_row][1] <= wr_val1;
			mat_q[wr_row][2] <= wr_val2;
			mat_q[wr_row][3] <= wr_val3;
		end
	end

	assign mat = mat_q;

endmodule

// ===== rtl/m4mul_datapath.sv =====
// Four-stage row-times-matrix pipeline: multiply, pair sums, column sums, saturate.
// Depends on m4mul_pkg. Each stage holds when its successor is full and stalled.
module m4mul_datapath import m4mul_pkg::*; #(
	parameter int FracBits = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mul_valid,
	output logic       mul_stall,
	input  logic [1:0] mul_row,
	input  elem_t      a0,
	input  elem_t      a1,
	input  elem_t      a2,
	input  elem_t      a3,
	input  mat_t       mat,
	output logic       res_valid,
	input  logic       res_stall,
	output out_beat_t  res_data
);

	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	elem_t a [MAT_DIM];

	logic signed [PROD_W-1:0] prod      [MAT_DIM][MAT_DIM];
	logic signed [PROD_W-1:0] prod_s1   [MAT_DIM][MAT_DIM];
	logic signed [PAIR_W-1:0] pair_s2   [MAT_DIM][2];
	logic signed [SUM_W-1:0]  sum_s3    [MAT_DIM];
	elem_t                    sat       [MAT_DIM];
	logic [MAT_DIM-1:0]       sat_ovf;

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [1:0] row_s1, row_s2, row_s3;
	out_beat_t  res_s4;
	logic       adv1, adv2, adv3, adv4;

	assign a[0] = a0;
	assign a[1] = a1;
	assign a[2] = a2;
	assign a[3] = a3;

	// Stage advance chain: a stage moves when empty or when the next one moves
	assign adv4      = !valid_s4 || !res_stall;
	assign adv3      = !valid_s3 || adv4;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign mul_stall = !adv1;

	// Sixteen 32x32 signed products
	always_comb begin
		for (int k = 0; k < MAT_DIM; k++) begin
			for (int j = 0; j < MAT_DIM; j++) begin
				prod[k][j] = PROD_W'(a[k]) * PROD_W'(mat[k][j]);
			end
		end
	end

	// Saturate each full-width column sum to 32 bits
	always_comb begin
		for (int j = 0; j < MAT_DIM; j++) begin
			if (sum_s3[j] > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
				sat[j]     = {1'b0, {(DATA_W-1){1'b1}}};
				sat_ovf[j] = 1'b1;
			end else if (sum_s3[j] < SUM_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
				sat[j]     = {1'b1, {(DATA_W-1){1'b0}}};
				sat_ovf[j] = 1'b1;
			end else begin
				sat[j]     = sum_s3[j][DATA_W-1:0];
				sat_ovf[j] = 1'b0;
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= mul_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv1) begin
			row_s1  <= mul_row;
			prod_s1 <= prod;
		end
		// shift each product down by the fraction bits, then add in pairs
		if (adv2) begin
			row_s2 <= row_s1;
			for (int j = 0; j < MAT_DIM; j++) begin
				pair_s2[j][0] <= PAIR_W'(prod_s1[0][j] >>> FracBits)
					+ PAIR_W'(prod_s1[1][j] >>> FracBits);
				pair_s2[j][1] <= PAIR_W'(prod_s1[2][j] >>> FracBits)
					+ PAIR_W'(prod_s1[3][j] >>> FracBits);
			end
		end
		if (adv3) begin
			row_s3 <= row_s2;
			for (int j = 0; j < MAT_DIM; j++) begin
				sum_s3[j] <= SUM_W'(pair_s2[j][0]) + SUM_W'(pair_s2[j][1]);
			end
		end
		if (adv4) begin
			res_s4.result_row <= row_s3;
			res_s4.product0   <= sat[0];
			res_s4.product1   <= sat[1];
			res_s4.product2   <= sat[2];
			res_s4.product3   <= sat[3];
			res_s4.overflow   <= |sat_ovf;
		end
	end

	assign res_valid = valid_s4;
	assign res_data  = res_s4;

endmodule

// ===== rtl/matrix4x4_multiply_core.sv =====
// 4x4 matrix product core, signed Q16.16. Throughput: one beat per cycle while
// in_stall is low, loads and multiplies mixed freely; a load writes its row at
// acceptance and is seen by a multiply in the next cycle. Load beats give no
// result. The 16 product multipliers set the first stage. Reset (arst_n low)
// clears the right-hand matrix to zero and empties the pipe.
module matrix4x4_multiply_core import m4mul_pkg::*; #(
	parameter int FracBits = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	mat_t mat;
	logic accept;
	logic wr_en;
	logic mul_valid;

	// Beat steering by opcode
	assign accept    = in_valid && !in_stall;
	assign wr_en     = accept && (in_data.op == OP_LOAD);
	assign mul_valid = in_valid && (in_data.op == OP_MUL);

	m4mul_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_row  (in_data.row_index),
		.wr_val0 (in_data.value0),
		.wr_val1 (in_data.value1),
		.wr_val2 (in_data.value2),
		.wr_val3 (in_data.value3),
		.mat     (mat)
	);

	m4mul_datapath #(
		.FracBits (FracBits)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.mul_valid (mul_valid),
		.mul_stall (in_stall),
		.mul_row   (in_data.row_index),
		.a0        (in_data.value0),
		.a1        (in_data.value1),
		.a2        (in_data.value2),
		.a3        (in_data.value3),
		.mat       (mat),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res_data  (out_data)
	);

endmodule
